// File: design/ssenc_pkg.sv
// package for the seven-segment serial encoder
// holds payload structs, the segment table and elaboration helpers; no dependencies
package ssenc_pkg;

  typedef struct packed {
    logic [9:0] value;
    logic       dot_one;
    logic       dot_two;
  } in_t;

  typedef struct packed {
    logic serial_bit;
    logic last_bit;
  } out_t;

  localparam logic [7:0] SEG_BLANK = 8'hFF;
  localparam logic [7:0] SEG_DOT   = 8'hFE;
  localparam int         BYTE_BITS = 8;
  localparam int         MAX_POS   = 3;

  // active-low segment pattern of one decimal digit
  function automatic logic [7:0] seg_of(input logic [3:0] d);
    logic [7:0] s;
    case (d)
      4'd0:    s = 8'h03;
      4'd1:    s = 8'h9F;
      4'd2:    s = 8'h25;
      4'd3:    s = 8'h0D;
      4'd4:    s = 8'h99;
      4'd5:    s = 8'h49;
      4'd6:    s = 8'h41;
      4'd7:    s = 8'h1F;
      4'd8:    s = 8'h01;
      4'd9:    s = 8'h09;
      default: s = SEG_BLANK;
    endcase
    return s;
  endfunction

  // 10 to the n, used only at elaboration
  function automatic int pow10(input int n);
    int r;
    r = 1;
    for (int i = 0; i < n; i++) begin
      r = r * 10;
    end
    return r;
  endfunction

endpackage

// File: design/ssenc_front.sv
// front end: holds the always-on-dot register, saturates the value,
// splits it into digits and builds the frame of segment bytes; uses ssenc_pkg
module ssenc_front import ssenc_pkg::*; #(
  parameter int DIGIT_COUNT = 3
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic                         cfg_wdata,
  input  in_t                          in_data,
  output logic [8*DIGIT_COUNT-1:0]     frame
);

  localparam logic [9:0] LIMIT = 10'(pow10(DIGIT_COUNT) - 1);

  logic        dot_always;
  logic [9:0]  val;
  logic [15:0] h_prod;
  logic [3:0]  hund;
  logic [9:0]  h100;
  logic [6:0]  rem;
  logic [13:0] t_prod;
  logic [3:0]  tens;
  logic [3:0]  units;
  logic [3:0]  digit [MAX_POS];
  logic        lit   [MAX_POS];
  logic [7:0]  byte_v [MAX_POS];
  logic        dot_pos;

  always_ff @(posedge clk) begin
    if (rst) begin
      dot_always <= 1'b0;
    end else if (cfg_we) begin
      dot_always <= cfg_wdata;
    end
  end

  always_comb begin
    val    = (in_data.value > LIMIT) ? LIMIT : in_data.value;
    // divide by 100 and by 10 through reciprocal multiplies, exact below 1000
    h_prod = 16'(val) * 16'd41;
    hund   = h_prod[15:12];
    h100   = 10'(hund) * 10'd100;
    rem    = 7'(val - h100);
    t_prod = 14'(rem) * 14'd103;
    tens   = t_prod[13:10];
    units  = 4'(rem - 7'(7'(tens) * 7'd10));
    digit[0] = units;
    digit[1] = tens;
    digit[2] = hund;
    // leading zeros stay blank
    lit[0] = (val != 10'd0);
    lit[1] = (val >= 10'd10);
    lit[2] = (val >= 10'd100);
    dot_pos = in_data.dot_two;

    for (int p = 0; p < MAX_POS; p++) begin
      byte_v[p] = (p == 1 && dot_always) ? SEG_DOT : SEG_BLANK;
      if (!in_data.dot_one && !in_data.dot_two) begin
        if (lit[p]) begin
          byte_v[p] = seg_of(digit[p]);
        end
      end else if (val == 10'd0) begin
        byte_v[p] = SEG_BLANK;
      end else if (val == 10'd1) begin
        byte_v[p] = (p == int'(dot_pos)) ? SEG_DOT : SEG_BLANK;
      end
    end

    // first bit sent sits at bit 0: top position first, each byte lsb first
    for (int k = 0; k < DIGIT_COUNT; k++) begin
      frame[BYTE_BITS*k +: BYTE_BITS] = byte_v[DIGIT_COUNT-1-k];
    end
  end

endmodule

// File: design/ssenc_fifo.sv
// small register queue of frames between front and back
// no dependencies
module ssenc_fifo #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: design/ssenc_back.sv
// back end: shifts one frame out a bit per beat and flags the last bit
// uses ssenc_pkg
module ssenc_back import ssenc_pkg::*; #(
  parameter int FW = 24
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          frame_valid,
  input  logic [FW-1:0] frame,
  output logic          frame_pop,
  output logic          empty,
  input  logic          pop,
  output out_t          out_data
);

  localparam int CW = $clog2(FW);

  logic          busy;
  logic [FW-1:0] shreg;
  logic [CW-1:0] cnt;
  logic          last;
  logic          load;

  assign last      = (cnt == CW'(FW - 1));
  assign load      = frame_valid && (!busy || (pop && last));
  assign frame_pop = load;
  assign empty     = !busy;

  always_comb begin
    out_data.serial_bit = shreg[0];
    out_data.last_bit   = last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (load) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (pop && busy) begin
      if (last) begin
        busy <= 1'b0;
      end else begin
        cnt <= cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      shreg <= frame;
    end else if (pop && busy) begin
      shreg <= shreg >> 1;
    end
  end

endmodule

// File: design/seven_segment_serial_encoder_top.sv
// top level of the seven-segment serial encoder
// uses ssenc_pkg, ssenc_front, ssenc_fifo and ssenc_back
//
// usage
//   input side is a queue: drive in_data and push; a beat is taken at a
//   rising edge with push high and full low. each beat carries a value
//   (saturated to 10^DIGIT_COUNT - 1) and two dot flags.
//   result side is a queue too: while empty is low, out_data shows the next
//   serial bit for the external shift register; pop takes it. last_bit marks
//   the final bit of a frame, after which the latch should be pulsed.
//   one input beat gives 8*DIGIT_COUNT result beats (24 by default), top
//   digit position first, each byte lsb first.
//   with queue and serializer free, an accepted frame is written into the
//   queue, then loaded into the serializer; its first bit is then on out_data to pop.
//   the serializer moves one bit per pop; with a frame waiting in the queue,
//   frames run back to back with no gap.
//   a queue of QUEUE_DEPTH frames sits between front and serializer, so new
//   values are taken while a frame is still shifting out.
//   if the receiver stalls, bits hold and the queue fills; full then rises.
//   reset (rst, synchronous) empties the queue, drops any frame in flight
//   and clears the always-on-dot register.
//   cfg_we/cfg_wdata write the always-on-dot register; write only when idle.
module seven_segment_serial_encoder_top import ssenc_pkg::*; #(
  parameter int DIGIT_COUNT = 3,   // 1 to 3 digit positions
  parameter int QUEUE_DEPTH = 2    // frames buffered, 2 or more
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic cfg_wdata,
  input  in_t  in_data,
  input  logic push,
  output logic full,
  output out_t out_data,
  output logic empty,
  input  logic pop
);

  localparam int FW = 8 * DIGIT_COUNT;

  logic [FW-1:0] front_frame;
  logic [FW-1:0] q_frame;
  logic          q_empty;
  logic          q_pop;

  // classify and build segment bytes for the incoming value
  ssenc_front #(
    .DIGIT_COUNT(DIGIT_COUNT)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .frame     (front_frame)
  );

  // frame queue decouples acceptance from shifting
  ssenc_fifo #(
    .WIDTH(FW),
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (front_frame),
    .full  (full),
    .pop   (q_pop),
    .rdata (q_frame),
    .empty (q_empty)
  );

  // serializer, one bit per result beat
  ssenc_back #(
    .FW(FW)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .frame_valid (!q_empty),
    .frame       (q_frame),
    .frame_pop   (q_pop),
    .empty       (empty),
    .pop         (pop),
    .out_data    (out_data)
  );

endmodule

// File: bench/tb_seven_segment_serial_encoder_top.sv
// testbench for seven_segment_serial_encoder_top: frame predictor, bit checker, drivers
// depends on ssenc_pkg and the encoder rtl only
module tb_seven_segment_serial_encoder_top import ssenc_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int          DIGITS      = 3;       // matches the block's default
  localparam int unsigned VALUE_MAX   = 999;     // 10^DIGITS - 1
  localparam int unsigned CYCLE_LIMIT = 400000;  // several times the slowest legal run
  localparam int unsigned LONG_HOLD   = 300;     // receiver hold-off, in cycles

  // active-low patterns for decimal digits 0..9
  localparam logic [7:0] DIGIT_SEG [0:9] = '{
    8'h03, 8'h9F, 8'h25, 8'h0D, 8'h99, 8'h49, 8'h41, 8'h1F, 8'h01, 8'h09
  };

  // predicts the 24 serial bits of each accepted value and checks popped bits
  class serial_frame_board;
    bit          dot_always;   // mirror of the always-on-dot register
    out_t        bits_due[$];  // serial bits still owed by the block, oldest first
    int unsigned errors;

    // expand one accepted beat into its frame of serial bits
    function void note_value(in_t b);
      logic [7:0]  seg [DIGITS];
      int unsigned v;
      int unsigned rest;
      int unsigned pos;
      v = b.value;
      if (v > VALUE_MAX) v = VALUE_MAX;
      // default bytes: all blank, middle dot lit when always-on is set
      for (int p = 0; p < DIGITS; p++) seg[p] = SEG_BLANK;
      if (dot_always) seg[1] = SEG_DOT;
      // plain number: digits from the units up, leading zeros stay blank
      if (!b.dot_one && !b.dot_two) begin
        rest = v;
        pos  = 0;
        while (rest > 0 && pos < DIGITS) begin
          seg[pos] = DIGIT_SEG[rest % 10];
          rest     = rest / 10;
          pos++;
        end
      end
      // dot modes in order, so the second dot wins when both are asked
      for (int d = 0; d < 2; d++) begin
        if ((d == 0) ? b.dot_one : b.dot_two) begin
          if (v <= 1) begin
            for (int p = 0; p < DIGITS; p++) seg[p] = SEG_BLANK;
            if (v == 1) seg[d] = SEG_DOT;
          end
        end
      end
      // top position first, each byte lsb first, last bit flagged
      for (int p = DIGITS - 1; p >= 0; p--) begin
        for (int i = 0; i < 8; i++) begin
          out_t o;
          o.serial_bit = seg[p][i];
          o.last_bit   = (p == 0 && i == 7);
          bits_due.push_back(o);
        end
      end
    endfunction

    function void check_bit(out_t got);
      out_t want;
      if (bits_due.size() == 0) begin
        $error("serial bit with nothing expected: serial_bit=%0b last_bit=%0b",
               got.serial_bit, got.last_bit);
        errors++;
        return;
      end
      want = bits_due.pop_front();
      if (got.serial_bit !== want.serial_bit) begin
        $error("serial_bit mismatch: expected %0b actual %0b", want.serial_bit, got.serial_bit);
        errors++;
      end
      if (got.last_bit !== want.last_bit) begin
        $error("last_bit mismatch: expected %0b actual %0b", want.last_bit, got.last_bit);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return bits_due.size();
    endfunction
  endclass

  logic clk;
  logic rst;
  logic cfg_we;
  logic cfg_wdata;
  in_t  in_data;
  logic push;
  logic full;
  out_t out_data;
  logic empty;
  logic pop;

  serial_frame_board board = new();

  // knobs shared between the stimulus and the receiver
  bit rx_idle_on = 1'b1;  // random pop gaps
  bit tx_idle_on = 1'b1;  // random push gaps
  bit hold_req   = 1'b0;  // asks the receiver for one long hold-off

  seven_segment_serial_encoder_top DUT (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_data  (in_data),
    .push     (push),
    .full     (full),
    .out_data (out_data),
    .empty    (empty),
    .pop      (pop)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // build an input beat from its fields
  function automatic in_t beat(int unsigned v, bit d1, bit d2);
    in_t b;
    b.value   = v[9:0];
    b.dot_one = d1;
    b.dot_two = d2;
    return b;
  endfunction

  // random beat: mostly in-range numbers, with weight on the edge regions
  function automatic in_t random_beat();
    int unsigned sel;
    int unsigned v;
    sel = $urandom_range(0, 15);
    if (sel == 0)      v = $urandom_range(1000, 1023);  // saturating values
    else if (sel <= 2) v = $urandom_range(0, 1);        // dot-mode triggers
    else if (sel <= 5) v = $urandom_range(2, 99);       // leading blanks
    else               v = $urandom_range(0, VALUE_MAX);
    return beat(v, $urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0);
  endfunction

  // push held low while the sender idles
  task automatic idle_input(int unsigned n);
    repeat (n) begin
      @(negedge clk);
      push = 1'b0;
    end
  endtask

  // offer one beat and hold it until the block takes it
  task automatic offer(in_t b);
    if (tx_idle_on && $urandom_range(0, 5) == 0) idle_input($urandom_range(1, 8));
    @(negedge clk);
    push    = 1'b1;
    in_data = b;
    do @(posedge clk); while (full);
    board.note_value(b);
  endtask

  // stop pushing and wait until every predicted bit has been popped
  task automatic settle();
    @(negedge clk);
    push = 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (4) @(negedge clk);  // margin after the last pop
  endtask

  // register write while the block is idle
  task automatic write_dot_always(bit v);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_wdata = v;
    board.dot_always = v;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // receiver: random pop bursts, one long hold on request, checks every popped bit
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    pop = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        stall_left = LONG_HOLD;
        hold_req   = 1'b0;
      end
      if (stall_left > 0) begin
        pop = 1'b0;
        stall_left--;
      end else if (rx_idle_on && $urandom_range(0, 9) == 0) begin
        pop        = 1'b0;
        stall_left = $urandom_range(0, 7);  // random length of the pop gap
      end else begin
        pop = 1'b1;
      end
      @(posedge clk);
      if (!rst && pop && !empty) board.check_bit(out_data);
    end
  end

  // watchdog
  initial begin
    int unsigned cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAIL seven_segment_serial_encoder_top");
    $finish;
  end

  // stimulus
  initial begin
    rst       = 1'b1;
    push      = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_wdata = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed, plain defaults
    write_dot_always(1'b0);
    offer(beat(0, 0, 0));      // zero shows all blank
    offer(beat(1, 0, 0));
    offer(beat(7, 0, 0));
    offer(beat(10, 0, 0));     // inner zero uses the table
    offer(beat(305, 0, 0));
    offer(beat(999, 0, 0));
    offer(beat(1000, 0, 0));   // saturates to 999
    offer(beat(1023, 0, 0));
    offer(beat(512, 0, 0));
    offer(beat(1, 1, 0));      // units dot
    offer(beat(0, 1, 0));      // dot mode blanks all
    offer(beat(5, 1, 0));      // dot mode, other value: defaults pass
    offer(beat(1, 0, 1));      // middle dot
    offer(beat(0, 0, 1));
    offer(beat(1, 1, 1));      // second dot overrides first
    offer(beat(1023, 1, 1));   // saturated value in dot mode
    settle();

    // directed, always-on dot
    write_dot_always(1'b1);
    offer(beat(0, 0, 0));      // only the always-on dot
    offer(beat(8, 0, 0));
    offer(beat(46, 0, 0));     // tens digit replaces the always-on dot
    offer(beat(1, 1, 0));      // dot pattern replaces the always-on dot
    offer(beat(1, 0, 1));
    offer(beat(0, 1, 0));
    offer(beat(7, 0, 1));      // defaults pass unchanged
    offer(beat(999, 0, 0));
    settle();

    // random, plain defaults; starts with a long receiver hold while the
    // sender keeps pushing so the queue fills and full rises
    write_dot_always(1'b0);
    hold_req   = 1'b1;
    tx_idle_on = 1'b0;
    repeat (30) offer(random_beat());
    tx_idle_on = 1'b1;
    repeat (60) offer(random_beat());
    settle();                  // sender pauses until everything has drained
    repeat (60) offer(random_beat());
    settle();

    // random, always-on dot
    write_dot_always(1'b1);
    repeat (150) offer(random_beat());
    settle();

    // final stretch with no idling on either side
    write_dot_always(1'b0);
    rx_idle_on = 1'b0;
    tx_idle_on = 1'b0;
    repeat (100) offer(random_beat());
    settle();
    repeat (30) @(posedge clk);  // any stray bit would show up here

    if (board.errors == 0) begin
      $display("PASS seven_segment_serial_encoder_top");
    end else begin
      $display("FAIL seven_segment_serial_encoder_top");
    end
    $finish;
  end

endmodule
